[design/raptor_code_parameter_derivation_macros.svh]
// Assertion macros for the checker file of the parameter derivation block.
// No dependencies; included by bare file name.
`ifndef RAPTOR_CODE_PARAMETER_DERIVATION_MACROS_SVH
`define RAPTOR_CODE_PARAMETER_DERIVATION_MACROS_SVH

// same-cycle implication under async active-low reset
`define RCPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcpd check failed");

// next-cycle implication under async active-low reset
`define RCPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcpd check failed");

`endif

[design/rcpd_pkg.sv]
// Shared types, constants and the central binomial table for the parameter derivation.
// No dependencies; imported by rcpd_ctrl, rcpd_dp and the top level.
package rcpd_pkg;

  localparam int unsigned KW = 14;
  localparam int unsigned NW = 15;
  localparam logic [13:0] LSat     = 14'h3FFF;
  localparam logic [4:0]  HLimit   = 5'd31;
  localparam logic [13:0] CeilDiv  = 14'd100;
  localparam logic [3:0]  DivTopBit = 4'd14;

  typedef struct packed {
    logic load_k;
    logic x_step;
    logic ceil_step;
    logic prime_start_s;
    logic prime_start_l;
    logic trial_init;
    logic div_start;
    logic div_step;
    logic trial_next;
    logic n_next;
    logic take_s;
    logic h_step;
    logic take_lp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic x_done;
    logic ceil_done;
    logic n_small;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
    logic h_done;
  } sts_t;

  // choose(h, ceil(h/2))
  function automatic logic [27:0] central_binom(input logic [4:0] h);
    logic [27:0] v;
    case (h)
      5'd0:    v = 28'd1;
      5'd1:    v = 28'd1;
      5'd2:    v = 28'd2;
      5'd3:    v = 28'd3;
      5'd4:    v = 28'd6;
      5'd5:    v = 28'd10;
      5'd6:    v = 28'd20;
      5'd7:    v = 28'd35;
      5'd8:    v = 28'd70;
      5'd9:    v = 28'd126;
      5'd10:   v = 28'd252;
      5'd11:   v = 28'd462;
      5'd12:   v = 28'd924;
      5'd13:   v = 28'd1716;
      5'd14:   v = 28'd3432;
      5'd15:   v = 28'd6435;
      5'd16:   v = 28'd12870;
      5'd17:   v = 28'd24310;
      5'd18:   v = 28'd48620;
      5'd19:   v = 28'd92378;
      5'd20:   v = 28'd184756;
      5'd21:   v = 28'd352716;
      5'd22:   v = 28'd705432;
      5'd23:   v = 28'd1352078;
      5'd24:   v = 28'd2704156;
      5'd25:   v = 28'd5200300;
      5'd26:   v = 28'd10400600;
      5'd27:   v = 28'd20058300;
      5'd28:   v = 28'd40116600;
      5'd29:   v = 28'd77558760;
      5'd30:   v = 28'd155117520;
      default: v = 28'hFFFFFFF;
    endcase
    return v;
  endfunction

endpackage

[design/rcpd_ctrl.sv]
// Sequencer for the parameter derivation: X search, ceil(K/100), prime tests, H search.
// Depends on rcpd_pkg; drives rcpd_dp through cmd_t and reads sts_t.
module rcpd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rcpd_pkg::cmd_t cmd_o,
  input  rcpd_pkg::sts_t sts_i
);
  import rcpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XSRCH, S_CEIL, S_PTEST, S_PLOOP, S_DIV, S_DEVAL, S_HSRCH, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   for_l_q, for_l_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    cmd         = '0;
    state_d     = state_q;
    for_l_d     = for_l_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load_k = 1'b1;
          state_d    = S_XSRCH;
        end
      end
      S_XSRCH: begin
        if (sts_i.x_done) state_d = S_CEIL;
        else cmd.x_step = 1'b1;
      end
      S_CEIL: begin
        if (sts_i.ceil_done) begin
          cmd.prime_start_s = 1'b1;
          for_l_d           = 1'b0;
          state_d           = S_PTEST;
        end else begin
          cmd.ceil_step = 1'b1;
        end
      end
      S_PTEST: begin
        if (sts_i.n_small) begin
          cmd.n_next = 1'b1;
        end else begin
          cmd.trial_init = 1'b1;
          state_d        = S_PLOOP;
        end
      end
      S_PLOOP: begin
        if (sts_i.sq_gt_n) begin
          if (for_l_q) begin
            cmd.take_lp = 1'b1;
            state_d     = S_DONE;
          end else begin
            cmd.take_s = 1'b1;
            state_d    = S_HSRCH;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DEVAL;
      end
      S_DEVAL: begin
        if (sts_i.rem_zero) begin
          cmd.n_next = 1'b1;
          state_d    = S_PTEST;
        end else begin
          cmd.trial_next = 1'b1;
          state_d        = S_PLOOP;
        end
      end
      S_HSRCH: begin
        if (sts_i.h_done) begin
          cmd.prime_start_l = 1'b1;
          for_l_d           = 1'b1;
          state_d           = S_PTEST;
        end else begin
          cmd.h_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      for_l_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      for_l_q     <= for_l_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/rcpd_dp.sv]
// Datapath: search counters, bit-serial remainder unit for trial division, result registers.
// Depends on rcpd_pkg; commanded by rcpd_ctrl.
module rcpd_dp (
  input  logic           clk_i,
  input  rcpd_pkg::cmd_t cmd_i,
  output rcpd_pkg::sts_t sts_o,
  input  logic [13:0]    source_count_i,
  output logic [7:0]     x_value_o,
  output logic [8:0]     ldpc_count_o,
  output logic [4:0]     half_count_o,
  output logic [4:0]     half_weight_o,
  output logic [13:0]    intermediate_count_o,
  output logic [13:0]    intermediate_prime_o
);
  import rcpd_pkg::*;

  logic [KW-1:0] k_q;
  logic [7:0]    x_q;
  logic [15:0]   p_q;
  logic [13:0]   r_q;
  logic [7:0]    q_q;
  logic [NW-1:0] n_q;
  logic [7:0]    d_q;
  logic [15:0]   sq_q;
  logic [8:0]    rem_q;
  logic [3:0]    idx_q;
  logic [8:0]    s_q;
  logic [4:0]    h_q;
  logic [NW-1:0] lp_q;

  logic [7:0]    x_val_q;
  logic [8:0]    s_val_q;
  logic [4:0]    h_val_q;
  logic [4:0]    hw_val_q;
  logic [13:0]   l_val_q;
  logic [13:0]   lp_val_q;

  logic [NW-1:0] ks;
  logic [NW-1:0] l_sum;
  logic [8:0]    rem_sh;
  logic [8:0]    rem_nx;
  logic [5:0]    h_inc;

  assign ks     = {1'b0, k_q} + {6'b0, s_q};
  assign l_sum  = ks + {10'b0, h_q};
  assign rem_sh = {rem_q[7:0], n_q[idx_q]};
  assign rem_nx = (rem_sh >= {1'b0, d_q}) ? (rem_sh - {1'b0, d_q}) : rem_sh;
  assign h_inc  = {1'b0, h_q} + 6'd1;

  assign sts_o.x_done    = (p_q >= {1'b0, k_q, 1'b0});
  assign sts_o.ceil_done = (r_q == 14'd0);
  assign sts_o.n_small   = (n_q < 15'd2);
  assign sts_o.sq_gt_n   = (sq_q > {1'b0, n_q});
  assign sts_o.div_last  = (idx_q == 4'd0);
  assign sts_o.rem_zero  = (rem_q == 9'd0);
  assign sts_o.h_done    = (h_q == HLimit) || (central_binom(h_q) >= {13'b0, ks});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_k) begin
      k_q <= source_count_i;
      x_q <= 8'd1;
      p_q <= 16'd0;
      r_q <= source_count_i;
      q_q <= 8'd0;
      h_q <= 5'd0;
    end
    if (cmd_i.x_step) begin
      p_q <= p_q + {7'b0, x_q, 1'b0};
      x_q <= x_q + 8'd1;
    end
    if (cmd_i.ceil_step) begin
      q_q <= q_q + 8'd1;
      r_q <= (r_q > CeilDiv) ? (r_q - CeilDiv) : 14'd0;
    end
    if (cmd_i.prime_start_s) n_q <= {7'b0, q_q} + {7'b0, x_q};
    if (cmd_i.prime_start_l) n_q <= l_sum;
    if (cmd_i.n_next)        n_q <= n_q + 15'd1;
    if (cmd_i.trial_init) begin
      d_q  <= 8'd2;
      sq_q <= 16'd4;
    end
    if (cmd_i.trial_next) begin
      d_q  <= d_q + 8'd1;
      sq_q <= sq_q + {7'b0, d_q, 1'b1};
    end
    if (cmd_i.div_start) begin
      rem_q <= 9'd0;
      idx_q <= DivTopBit;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_nx;
      idx_q <= idx_q - 4'd1;
    end
    if (cmd_i.take_s)  s_q  <= n_q[8:0];
    if (cmd_i.h_step)  h_q  <= h_q + 5'd1;
    if (cmd_i.take_lp) lp_q <= n_q;
    if (cmd_i.out_load) begin
      x_val_q  <= x_q;
      s_val_q  <= s_q;
      h_val_q  <= h_q;
      hw_val_q <= h_inc[5:1];
      l_val_q  <= l_sum[NW-1] ? LSat : l_sum[13:0];
      lp_val_q <= lp_q[NW-1] ? LSat : lp_q[13:0];
    end
  end

  assign x_value_o            = x_val_q;
  assign ldpc_count_o         = s_val_q;
  assign half_count_o         = h_val_q;
  assign half_weight_o        = hw_val_q;
  assign intermediate_count_o = l_val_q;
  assign intermediate_prime_o = lp_val_q;

endmodule

[design/raptor_code_parameter_derivation.sv]
// Work per source count: the X search, the ceil(K/100) loop, trial division of each prime
// candidate for S and L' in the shared bit-serial remainder unit, and the H search.
// Throughput: one item at a time; the next transfer is taken once the result is registered.
// Reset: rst_ni asynchronous, active low, clears the sequencer and the output valid.
// Top level: rcpd_ctrl + rcpd_dp; depends on rcpd_pkg.
module raptor_code_parameter_derivation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [13:0] source_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  x_value_o,
  output logic [8:0]  ldpc_count_o,
  output logic [4:0]  half_count_o,
  output logic [4:0]  half_weight_o,
  output logic [13:0] intermediate_count_o,
  output logic [13:0] intermediate_prime_o
);
  import rcpd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rcpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rcpd_dp u_dp (
    .clk_i                (clk_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .source_count_i       (source_count_i),
    .x_value_o            (x_value_o),
    .ldpc_count_o         (ldpc_count_o),
    .half_count_o         (half_count_o),
    .half_weight_o        (half_weight_o),
    .intermediate_count_o (intermediate_count_o),
    .intermediate_prime_o (intermediate_prime_o)
  );

endmodule

[design/rcpd_checker.sv]
// Port-level checks for raptor_code_parameter_derivation, bound to the top level.
// Depends on raptor_code_parameter_derivation_macros.svh.
`include "raptor_code_parameter_derivation_macros.svh"

module rcpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [8:0]  ldpc_count_o,
  input logic [4:0]  half_count_o,
  input logic [4:0]  half_weight_o,
  input logic [13:0] intermediate_count_o,
  input logic [13:0] intermediate_prime_o
);

  logic [5:0] h_inc;
  assign h_inc = {1'b0, half_count_o} + 6'd1;

  `RCPD_ASSERT_NXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `RCPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `RCPD_ASSERT_IMP(a_half_weight, clk_i, rst_ni, out_valid_o, half_weight_o == h_inc[5:1])
  `RCPD_ASSERT_IMP(a_prime_order, clk_i, rst_ni, out_valid_o,
                   (intermediate_prime_o >= intermediate_count_o) && (ldpc_count_o >= 9'd2))

endmodule

bind raptor_code_parameter_derivation rcpd_checker u_rcpd_checker (.*);

[sim/rcpd_checker.sv]
// Scoreboard for raptor_code_parameter_derivation: watches both valid/stall channels,
// derives X, S, H, H', L and L' for each source count transfer and compares in order.
// Depends on rcpd_pkg for the L saturation value and the H search bound.
module rcpd_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [13:0] source_count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  x_value_i,
  input  logic [8:0]  ldpc_count_i,
  input  logic [4:0]  half_count_i,
  input  logic [4:0]  half_weight_i,
  input  logic [13:0] intermediate_count_i,
  input  logic [13:0] intermediate_prime_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rcpd_pkg::*;

  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  s;
    logic [4:0]  h;
    logic [4:0]  h_half;
    logic [13:0] l;
    logic [13:0] l_prime;
  } code_params_t;

  code_params_t params_q[$];
  int fails = 0;
  int checked = 0;

  function automatic bit is_prime(int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned prime_from(int unsigned n);
    while (!is_prime(n)) n++;
    return n;
  endfunction

  // choose(n, ceil(n/2)) equals choose(n, floor(n/2))
  function automatic longint unsigned central_choose(int unsigned n);
    longint unsigned acc;
    int unsigned r;
    int unsigned i;
    acc = 1;
    r = n / 2;
    for (i = 1; i <= r; i++) acc = acc * (n - r + i) / i;
    return acc;
  endfunction

  function automatic code_params_t derive_params(logic [13:0] k_in);
    code_params_t p;
    int unsigned k;
    int unsigned x;
    int unsigned s;
    int unsigned h;
    int unsigned l;
    int unsigned lp;
    k = k_in;
    x = 1;
    while (x * (x - 1) < 2 * k) x++;
    s = prime_from((k + 99) / 100 + x);
    h = 0;
    while (h < HLimit && central_choose(h) < longint'(k + s)) h++;
    l = k + s + h;
    lp = prime_from(l);
    p.x       = 8'(x);
    p.s       = 9'(s);
    p.h       = 5'(h);
    p.h_half  = 5'((h + 1) / 2);
    p.l       = (l > LSat) ? LSat : 14'(l);
    p.l_prime = (lp > LSat) ? LSat : 14'(lp);
    return p;
  endfunction

  function automatic void flag(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    code_params_t got;
    code_params_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) params_q = {params_q, derive_params(source_count_i)};
      if (out_valid_i && !out_stall_i) begin
        got = '{x_value_i, ldpc_count_i, half_count_i, half_weight_i,
                intermediate_count_i, intermediate_prime_i};
        if (params_q.size() == 0) begin
          flag($sformatf("unexpected result X=%0d S=%0d H=%0d H'=%0d L=%0d L'=%0d",
                         got.x, got.s, got.h, got.h_half, got.l, got.l_prime));
        end else begin
          want = params_q.pop_front();
          checked++;
          if (got !== want) begin
            flag($sformatf({"mismatch exp X=%0d S=%0d H=%0d H'=%0d L=%0d L'=%0d",
                            " got X=%0d S=%0d H=%0d H'=%0d L=%0d L'=%0d"},
                           want.x, want.s, want.h, want.h_half, want.l, want.l_prime,
                           got.x, got.s, got.h, got.h_half, got.l, got.l_prime));
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= params_q.size();
    checked_o    <= checked;
  end

endmodule

[sim/tb_raptor_code_parameter_derivation.sv]
// Testbench top for raptor_code_parameter_derivation: drives source counts under
// several idle/stall mixes and reports the verdict from rcpd_scoreboard.
// Depends on the RTL (rcpd_pkg and the top level) and sim/rcpd_checker.sv.
module tb_raptor_code_parameter_derivation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RandomCount = 132;
  localparam int          DrainCycles = 5000;
  localparam int unsigned MaxK        = 8192;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [13:0] source_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  x_value;
  logic [8:0]  ldpc_count;
  logic [4:0]  half_count;
  logic [4:0]  half_weight;
  logic [13:0] intermediate_count;
  logic [13:0] intermediate_prime;
  int          fail_count;
  int          pending;
  int          checked;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int          sent_counts = 0;

  logic [13:0] directed_counts[] = '{
    14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd99, 14'd100, 14'd101, 14'd1000,
    14'd8191, 14'd8192, 14'd8193, 14'h1555, 14'h2AAA, 14'd16000, 14'd16350,
    14'd16382, 14'h3FFF
  };

  always #6 clk = ~clk;

  raptor_code_parameter_derivation u_top (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .source_count_i       (source_count),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .x_value_o            (x_value),
    .ldpc_count_o         (ldpc_count),
    .half_count_o         (half_count),
    .half_weight_o        (half_weight),
    .intermediate_count_o (intermediate_count),
    .intermediate_prime_o (intermediate_prime)
  );

  rcpd_scoreboard u_checker (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .source_count_i       (source_count),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .x_value_i            (x_value),
    .ldpc_count_i         (ldpc_count),
    .half_count_i         (half_count),
    .half_weight_i        (half_weight),
    .intermediate_count_i (intermediate_count),
    .intermediate_prime_i (intermediate_prime),
    .fail_count_o         (fail_count),
    .pending_o            (pending),
    .checked_o            (checked)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_count(input logic [13:0] k);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    source_count <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_counts++;
  endtask

  function automatic logic [13:0] pick_count();
    case ($urandom_range(9))
      0:       return 14'($urandom_range(0, 150));
      1, 2:    return 14'($urandom_range(MaxK + 1, 16383));
      default: return 14'($urandom_range(1, MaxK));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_counts[i]) send_count(directed_counts[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 52; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      repeat (RandomCount / 4) send_count(pick_count());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("%0d source counts sent (%0d directed, K over the full 14-bit range)",
             sent_counts, directed_counts.size());
    $display("%0d parameter sets checked under four idle/stall mixes", checked);
    if (fail_count == 0) begin
      $display("tb_raptor_code_parameter_derivation passed");
    end else begin
      $display("tb_raptor_code_parameter_derivation failed");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_raptor_code_parameter_derivation failed");
    $finish;
  end

endmodule
